### design/umc_pkg.sv
// Shared types, codes and defaults for the universal machine core.
package umc_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_NUM_ARRAYS  = 64;
   localparam int DEF_ARRAY_DEPTH = 1024;

   // Fixed architectural sizes.
   localparam int NUM_REGS  = 8;
   localparam int REG_AW    = 3;
   localparam int PC_OUT_W  = 10;
   localparam int OPC_LSB   = 28;
   localparam int IMM_A_LSB = 25;
   localparam logic [31:0] IMM_MASK = 32'd33554431;
   localparam logic [31:0] OUT_MAX  = 32'd255;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_HALT   = 2'd1;
   localparam logic [1:0] ST_FAULT  = 2'd2;
   localparam logic [1:0] ST_NOSLOT = 2'd3;

   // Run state codes.
   localparam logic [1:0] RUN_GO    = 2'd0;
   localparam logic [1:0] RUN_HALT  = 2'd1;
   localparam logic [1:0] RUN_FAULT = 2'd2;

   // Input actions.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   // Opcodes.
   localparam logic [3:0] OP_CMOV  = 4'd0;
   localparam logic [3:0] OP_INDEX = 4'd1;
   localparam logic [3:0] OP_AMEND = 4'd2;
   localparam logic [3:0] OP_ADD   = 4'd3;
   localparam logic [3:0] OP_MUL   = 4'd4;
   localparam logic [3:0] OP_DIV   = 4'd5;
   localparam logic [3:0] OP_NAND  = 4'd6;
   localparam logic [3:0] OP_HALT  = 4'd7;
   localparam logic [3:0] OP_ALLOC = 4'd8;
   localparam logic [3:0] OP_FREE  = 4'd9;
   localparam logic [3:0] OP_OUT   = 4'd10;
   localparam logic [3:0] OP_IN    = 4'd11;
   localparam logic [3:0] OP_LDPRG = 4'd12;
   localparam logic [3:0] OP_ORTH  = 4'd13;

   // Input word.
   typedef struct packed {
      logic        action;
      logic [31:0] data_word;
   } umc_req_type;

   // Result word.
   typedef struct packed {
      logic [1:0] status;
      logic       out_valid;
      logic [7:0] out_byte;
      logic       input_taken;
      logic [9:0] pc_now;
   } umc_rsp_type;

   // Classified command held in the queue between front and back.
   typedef struct packed {
      logic        is_step;
      logic [31:0] data;
   } umc_cmd_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic        valid;
      umc_cmd_type cmd;
   } umc_head_type;

endpackage

### design/umc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module umc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### design/umc_div.sv
// Restoring divider, one quotient bit a cycle.
module umc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [32:0] trial;

   // One shift-and-subtract step per cycle.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], quo_ff[31]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial[32]) begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

### design/umc_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module umc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  umc_pkg::umc_req_type req_item,
   input  logic                 pop,
   output umc_pkg::umc_head_type head
);
   import umc_pkg::*;

   umc_cmd_type ent_ff [2];
   logic        wptr_ff, wptr_in;
   logic        rptr_ff, rptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   umc_cmd_type cmd;

   // Classify the incoming word.
   always_comb begin
      cmd.is_step = (req_item.action == ACT_STEP);
      cmd.data    = req_item.data_word;
   end

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;

   // Pointer and fill count updates.
   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         ent_ff[wptr_ff] <= cmd;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.cmd   = ent_ff[rptr_ff];
endmodule

### design/umc_back.sv
// Back end: fetches, decodes and executes queued words against the machine state.
module umc_back #(
   parameter int NUM_ARRAYS  = umc_pkg::DEF_NUM_ARRAYS,
   parameter int ARRAY_DEPTH = umc_pkg::DEF_ARRAY_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  umc_pkg::umc_head_type head,
   output logic                  pop,
   output logic                  rsp_strobe,
   output umc_pkg::umc_rsp_type  rsp_item
);
   import umc_pkg::*;

   localparam int SW  = $clog2(NUM_ARRAYS);
   localparam int OW  = $clog2(ARRAY_DEPTH);
   localparam int LW  = OW + 1;
   localparam int AW  = SW + OW;
   localparam int PCW = OW + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_EXEC  = 4'd3;
   localparam logic [3:0] S_LDW   = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_SCAN  = 4'd7;
   localparam logic [3:0] S_ZFILL = 4'd8;
   localparam logic [3:0] S_COPY  = 4'd9;

   logic [3:0]            state_ff, state_in;
   logic [31:0]           ir_ff, ir_in;
   logic [31:0]           data_ff, data_in;
   logic [31:0]           ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in;
   logic [2:0]            rv_ff, rv_in;
   logic [PCW-1:0]        pc_ff, pc_in;
   logic [LW-1:0]         len0_ff, len0_in;
   logic [1:0]            run_ff, run_in;
   logic [NUM_ARRAYS-1:0] active_ff, active_in;
   logic [NUM_REGS-1:0]   regv_ff, regv_in;
   logic [SW-1:0]         scan_ff, scan_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic [LW-1:0]         cnt_ff, cnt_in;
   logic [LW-1:0]         cap_ff, cap_in;
   logic [31:0]           prod_ff, prod_in;
   logic                  wpend_ff, wpend_in;
   logic [OW-1:0]         widx_ff, widx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   umc_rsp_type           rsp_ff, rsp_in;

   // Memory ports.
   logic              w_we;
   logic [AW-1:0]     w_wa, w_ra;
   logic [31:0]       w_wd, w_q;
   logic              r_we;
   logic [REG_AW-1:0] r_wa, r_ra_a, r_ra_b, r_ra_c;
   logic [31:0]       r_wd, r_qa, r_qb, r_qc;
   logic              l_we;
   logic [SW-1:0]     l_wa, l_ra;
   logic [LW-1:0]     l_wd, l_q;

   // Divider.
   logic        div_start, div_done;
   logic [31:0] div_quo;

   // Decode and helpers.
   logic [3:0]  op;
   logic [31:0] va, vb, vc, sel;
   logic        sel_ok;
   logic [31:0] sel_len;

   // Completion of an item.
   logic           fin;
   logic [1:0]     fst;
   logic           fsoft;
   logic           fov;
   logic [7:0]     fob;
   logic           fit;
   logic [PCW-1:0] fnext;

   umc_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_words (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(w_ra), .rd_data(w_q)
   );
   umc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_regs_a (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra_a), .rd_data(r_qa)
   );
   umc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_regs_b (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra_b), .rd_data(r_qb)
   );
   umc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_regs_c (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra_c), .rd_data(r_qc)
   );
   umc_ram #(.WIDTH(LW), .DEPTH(NUM_ARRAYS)) u_lens (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_addr(l_ra), .rd_data(l_q)
   );
   umc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(rb_ff),
      .divisor(rc_ff), .done(div_done), .quotient(div_quo)
   );

   // Register operands as read, with never-written registers reading as zero.
   assign op = ir_ff[31:OPC_LSB];
   assign va = rv_ff[0] ? r_qa : 32'd0;
   assign vb = rv_ff[1] ? r_qb : 32'd0;
   assign vc = rv_ff[2] ? r_qc : 32'd0;

   // Array selected by the instruction, its usability and its length.
   always_comb begin
      case (op)
         OP_AMEND: sel = ra_ff;
         OP_FREE:  sel = rc_ff;
         default:  sel = rb_ff;
      endcase
      sel_ok = (sel < 32'(NUM_ARRAYS)) && active_ff[sel[SW-1:0]];
      if (sel == 32'd0) begin
         sel_len = 32'(len0_ff);
      end else if (sel_ok) begin
         sel_len = 32'(l_q);
      end else begin
         sel_len = 32'd0;
      end
   end

   // Main sequencer.
   always_comb begin
      state_in  = state_ff;
      ir_in     = ir_ff;
      data_in   = data_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      rc_in     = rc_ff;
      rv_in     = rv_ff;
      pc_in     = pc_ff;
      len0_in   = len0_ff;
      run_in    = run_ff;
      active_in = active_ff;
      regv_in   = regv_ff;
      scan_in   = scan_ff;
      slot_in   = slot_ff;
      cnt_in    = cnt_ff;
      cap_in    = cap_ff;
      prod_in   = prod_ff;
      wpend_in  = 1'b0;
      widx_in   = widx_ff;
      rsp_valid_in = 1'b0;
      rsp_in    = rsp_ff;
      pop       = 1'b0;
      w_we      = 1'b0;
      w_wa      = '0;
      w_wd      = 32'd0;
      w_ra      = '0;
      r_we      = 1'b0;
      r_wa      = '0;
      r_wd      = 32'd0;
      r_ra_a    = w_q[8:6];
      r_ra_b    = w_q[5:3];
      r_ra_c    = w_q[2:0];
      l_we      = 1'b0;
      l_wa      = '0;
      l_wd      = '0;
      l_ra      = sel[SW-1:0];
      div_start = 1'b0;
      fin       = 1'b0;
      fst       = ST_OK;
      fsoft     = 1'b0;
      fov       = 1'b0;
      fob       = 8'd0;
      fit       = 1'b0;
      fnext     = pc_ff + PCW'(1);

      case (state_ff)
         // Take the next queued word; loads, dead steps and steps past the program end finish here.
         S_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               data_in = head.cmd.data;
               w_ra    = {SW'(0), pc_ff[OW-1:0]};
               if (!head.cmd.is_step) begin
                  if (len0_ff < LW'(ARRAY_DEPTH)) begin
                     w_we    = 1'b1;
                     w_wa    = {SW'(0), len0_ff[OW-1:0]};
                     w_wd    = head.cmd.data;
                     len0_in = len0_ff + LW'(1);
                  end
                  fin   = 1'b1;
                  fst   = run_ff;
                  fnext = pc_ff;
               end else if (run_ff != RUN_GO) begin
                  fin   = 1'b1;
                  fst   = run_ff;
                  fnext = pc_ff;
               end else if (32'(pc_ff) >= 32'(len0_ff)) begin
                  // Running off the end of the program reports a fault but keeps running.
                  fin   = 1'b1;
                  fst   = ST_FAULT;
                  fsoft = 1'b1;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end

         // Instruction word arrives; read its three registers.
         S_FETCH: begin
            ir_in    = w_q;
            rv_in    = {regv_ff[w_q[2:0]], regv_ff[w_q[5:3]], regv_ff[w_q[8:6]]};
            state_in = S_READ;
         end

         // Operands arrive; look up the length of the selected array.
         S_READ: begin
            ra_in    = va;
            rb_in    = vb;
            rc_in    = vc;
            case (op)
               OP_AMEND: l_ra = va[SW-1:0];
               OP_FREE:  l_ra = vc[SW-1:0];
               default:  l_ra = vb[SW-1:0];
            endcase
            state_in = S_EXEC;
         end

         S_EXEC: begin
            fin = 1'b1;
            case (op)
               OP_CMOV: begin
                  if (rc_ff != 32'd0) begin
                     r_we = 1'b1;
                     r_wa = ir_ff[8:6];
                     r_wd = rb_ff;
                  end
               end
               OP_INDEX: begin
                  if (!sel_ok || rc_ff >= sel_len) begin
                     fst = ST_FAULT;
                  end else begin
                     fin      = 1'b0;
                     w_ra     = {rb_ff[SW-1:0], rc_ff[OW-1:0]};
                     state_in = S_LDW;
                  end
               end
               OP_AMEND: begin
                  if (!sel_ok || rb_ff >= sel_len) begin
                     fst = ST_FAULT;
                  end else begin
                     w_we = 1'b1;
                     w_wa = {ra_ff[SW-1:0], rb_ff[OW-1:0]};
                     w_wd = rc_ff;
                  end
               end
               OP_ADD: begin
                  r_we = 1'b1;
                  r_wa = ir_ff[8:6];
                  r_wd = rb_ff + rc_ff;
               end
               OP_MUL: begin
                  fin      = 1'b0;
                  prod_in  = rb_ff * rc_ff;
                  state_in = S_MUL;
               end
               OP_DIV: begin
                  if (rc_ff == 32'd0) begin
                     fst = ST_FAULT;
                  end else begin
                     fin       = 1'b0;
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               OP_NAND: begin
                  r_we = 1'b1;
                  r_wa = ir_ff[8:6];
                  r_wd = ~(rb_ff & rc_ff);
               end
               OP_HALT: begin
                  fst   = ST_HALT;
                  fnext = pc_ff;
               end
               OP_ALLOC: begin
                  if (rc_ff > 32'(ARRAY_DEPTH)) begin
                     fst = ST_FAULT;
                  end else begin
                     fin      = 1'b0;
                     cap_in   = rc_ff[LW-1:0];
                     scan_in  = SW'(1);
                     state_in = S_SCAN;
                  end
               end
               OP_FREE: begin
                  if (rc_ff == 32'd0 || !sel_ok) begin
                     fst = ST_FAULT;
                  end else begin
                     active_in[rc_ff[SW-1:0]] = 1'b0;
                  end
               end
               OP_OUT: begin
                  if (rc_ff > OUT_MAX) begin
                     fst = ST_FAULT;
                  end else begin
                     fov = 1'b1;
                     fob = rc_ff[7:0];
                  end
               end
               OP_IN: begin
                  r_we = 1'b1;
                  r_wa = ir_ff[2:0];
                  r_wd = data_ff;
                  fit  = 1'b1;
               end
               OP_LDPRG: begin
                  if (rb_ff != 32'd0 && !sel_ok) begin
                     fst = ST_FAULT;
                  end else if (rc_ff >= sel_len) begin
                     fst = ST_FAULT;
                  end else if (rb_ff == 32'd0) begin
                     fnext = rc_ff[PCW-1:0];
                  end else begin
                     fin      = 1'b0;
                     slot_in  = rb_ff[SW-1:0];
                     cap_in   = sel_len[LW-1:0];
                     cnt_in   = '0;
                     state_in = S_COPY;
                  end
               end
               OP_ORTH: begin
                  r_we = 1'b1;
                  r_wa = ir_ff[IMM_A_LSB+2:IMM_A_LSB];
                  r_wd = ir_ff & IMM_MASK;
               end
               default: begin
               end
            endcase
         end

         // Array word arrives for an index instruction.
         S_LDW: begin
            r_we = 1'b1;
            r_wa = ir_ff[8:6];
            r_wd = w_q;
            fin  = 1'b1;
         end

         S_MUL: begin
            r_we = 1'b1;
            r_wa = ir_ff[8:6];
            r_wd = prod_ff;
            fin  = 1'b1;
         end

         S_DIV: begin
            if (div_done) begin
               r_we = 1'b1;
               r_wa = ir_ff[8:6];
               r_wd = div_quo;
               fin  = 1'b1;
            end
         end

         // Look for a free slot, one slot a cycle.
         S_SCAN: begin
            if (!active_ff[scan_ff]) begin
               active_in[scan_ff] = 1'b1;
               l_we    = 1'b1;
               l_wa    = scan_ff;
               l_wd    = cap_ff;
               r_we    = 1'b1;
               r_wa    = ir_ff[5:3];
               r_wd    = 32'(scan_ff);
               slot_in = scan_ff;
               cnt_in  = '0;
               if (cap_ff == LW'(0)) begin
                  fin = 1'b1;
               end else begin
                  state_in = S_ZFILL;
               end
            end else if (scan_ff == SW'(NUM_ARRAYS - 1)) begin
               fin = 1'b1;
               fst = ST_NOSLOT;
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end

         // Clear the new array one word a cycle.
         S_ZFILL: begin
            w_we   = 1'b1;
            w_wa   = {slot_ff, cnt_ff[OW-1:0]};
            w_wd   = 32'd0;
            cnt_in = cnt_ff + LW'(1);
            if (cnt_ff + LW'(1) == cap_ff) begin
               fin = 1'b1;
            end
         end

         // Copy the source array into array 0: read one word, write the previous.
         S_COPY: begin
            if (cnt_ff < cap_ff) begin
               w_ra     = {slot_ff, cnt_ff[OW-1:0]};
               cnt_in   = cnt_ff + LW'(1);
               wpend_in = 1'b1;
               widx_in  = cnt_ff[OW-1:0];
            end
            if (wpend_ff) begin
               w_we = 1'b1;
               w_wa = {SW'(0), widx_ff};
               w_wd = w_q;
            end
            if (cnt_ff == cap_ff && !wpend_ff) begin
               len0_in = cap_ff;
               fin     = 1'b1;
               fnext   = rc_ff[PCW-1:0];
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Retire the item: faults freeze the pc, halts stop the machine.
      if (fin) begin
         if (fst == ST_FAULT) begin
            if (!fsoft) begin
               run_in = RUN_FAULT;
            end
         end else begin
            if (fst == ST_HALT) begin
               run_in = RUN_HALT;
            end
            pc_in = fnext;
         end
         if (r_we) begin
            regv_in[r_wa] = 1'b1;
         end
         rsp_valid_in       = 1'b1;
         rsp_in.status      = fst;
         rsp_in.out_valid   = fov;
         rsp_in.out_byte    = fob;
         rsp_in.input_taken = fit;
         rsp_in.pc_now      = PC_OUT_W'(pc_in);
         state_in           = S_IDLE;
      end else if (r_we) begin
         regv_in[r_wa] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         len0_ff      <= '0;
         run_ff       <= RUN_GO;
         active_ff    <= NUM_ARRAYS'(1);
         regv_ff      <= '0;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         len0_ff      <= len0_in;
         run_ff       <= run_in;
         active_ff    <= active_in;
         regv_ff      <= regv_in;
         wpend_ff     <= wpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ir_ff   <= ir_in;
      data_ff <= data_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      rc_ff   <= rc_in;
      rv_ff   <= rv_in;
      scan_ff <= scan_in;
      slot_ff <= slot_in;
      cnt_ff  <= cnt_in;
      cap_ff  <= cap_in;
      prod_ff <= prod_in;
      widx_ff <= widx_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;
endmodule

### design/universal_machine_core.sv
// Top level of the universal machine core: front end, command queue and back end.
//
// Usage: drive req_item and raise start; the word is taken at a clock edge
// where start is high and busy is low. A load word appends data_word to
// array 0; a step word executes one instruction, and data_word is the value
// an input instruction takes. Every word gives exactly one result word on
// rsp_item, shown for one cycle with rsp_strobe high; results come in order.
// A two-entry queue sits between the front end and the back end, so busy
// only rises when both entries wait behind an instruction in progress.
// A load word passes the queue and finishes in the back end's idle state;
// a step for an ordinary instruction goes through queue, fetch, register
// read, execute and result, index and multiply go through a further state
// to write the register, divide waits on the one-bit-a-cycle divider,
// allocation searches up to NUM_ARRAYS-1 slots and then zero fills one word
// a cycle, and a program load from another array copies one word a cycle (the single word-store port).
// Reset is synchronous and active high: registers read as zero, array 0 is
// empty and the only active array, the pc is zero and the machine runs.
// No clearing pass is needed after reset. The receiver cannot stall.
module universal_machine_core #(
   parameter int NUM_ARRAYS  = umc_pkg::DEF_NUM_ARRAYS,
   parameter int ARRAY_DEPTH = umc_pkg::DEF_ARRAY_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  umc_pkg::umc_req_type req_item,
   output logic                 rsp_strobe,
   output umc_pkg::umc_rsp_type rsp_item
);
   import umc_pkg::*;

   umc_head_type head;
   logic         pop;

   umc_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .pop(pop), .head(head)
   );

   umc_back #(.NUM_ARRAYS(NUM_ARRAYS), .ARRAY_DEPTH(ARRAY_DEPTH)) u_back (
      .clock(clock), .reset(reset), .head(head), .pop(pop),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

`ifndef ASSERT_OFF
   // An emitted byte only comes with a successful instruction.
   a_out_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.out_valid |-> rsp_item.status == ST_OK)
      else $error("output byte with non-ok status");

   // Input and output never happen in one word, and input comes only with ok status.
   a_in_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.input_taken |-> !rsp_item.out_valid &&
      rsp_item.status == ST_OK)
      else $error("input taken together with output or failure");

   // A popped queue entry must exist.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");
`endif
endmodule
